[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL files that include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OTSU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OTSU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OTSU_ASSERT(label, clk, rst, prop, msg)
`define OTSU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[hw/rtl/otsu_pkg.sv]
// Constants and types of the Otsu threshold finder.
package otsu_pkg;
   localparam int LEVELS     = 256;
   localparam int LVL_W      = 8;
   localparam int CNT_W      = 21;
   localparam int SUM_W      = 29;
   localparam int MAX_PIXELS = 1048576;
   localparam int PROD_W     = 49;
   localparam int DEN_W      = 41;
   localparam int DSQ_W      = 98;
   localparam int MUL_B_W    = 49;
   localparam int MUL_P_W    = 139;

   typedef struct packed {
      logic               start;
      logic [DSQ_W-1:0]   a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [MUL_P_W-1:0] prod;
   } mul_sts_type;
endpackage

[hw/rtl/otsu_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle, stops when bits run out.
module otsu_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  otsu_pkg::mul_req_type req,
   output otsu_pkg::mul_sts_type sts
);
   logic [otsu_pkg::MUL_P_W-1:0] acc_ff, acc_in;
   logic [otsu_pkg::MUL_P_W-1:0] a_ff, a_in;
   logic [otsu_pkg::MUL_B_W-1:0] b_ff, b_in;
   logic                         busy_ff, busy_in;
   logic                         done;

   assign done = busy_ff && (b_ff == '0);

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      if (req.start) begin
         acc_in  = '0;
         a_in    = otsu_pkg::MUL_P_W'(req.a);
         b_in    = req.b;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = {a_ff[otsu_pkg::MUL_P_W-2:0], 1'b0};
         b_in = {1'b0, b_ff[otsu_pkg::MUL_B_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done;
   assign sts.prod = acc_ff;
endmodule

[hw/rtl/otsu_threshold_finder_top.sv]
// Otsu threshold finder: histogram counting and sequenced threshold search.
//
//   channel | dir | ports                                   | beat
//   req     | in  | req_valid req_stall req_pixel req_last_pixel | one pixel
//   rsp     | out | rsp_valid rsp_stall rsp_threshold rsp_pixel_total | one frame result
//
// A pixel is handled as a histogram read, then a read-modify-write of the bin.
// On the last pixel the 256 bins are swept through one shared shift-add
// multiplier; each level costs up to 7 products, each at one multiplier bit
// per cycle (at most 49 bits).
// Reset clears per-bin valid flags at once; no clearing pass is needed.
// A result held by rsp_stall blocks the end of the next frame's sweep, and req_stall stays high meanwhile.
module otsu_threshold_finder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [otsu_pkg::LVL_W-1:0]    req_pixel,
   input  logic                          req_last_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [otsu_pkg::LVL_W-1:0]    rsp_threshold,
   output logic [otsu_pkg::CNT_W-1:0]    rsp_pixel_total
);
   `include "assert_macros.svh"

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INC  = 7'b0000010,
      ST_RD   = 7'b0000100,
      ST_BIN  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_EVAL = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef enum logic [6:0] {
      STEP_U   = 7'b0000001,
      STEP_A   = 7'b0000010,
      STEP_B   = 7'b0000100,
      STEP_DEN = 7'b0001000,
      STEP_SQ  = 7'b0010000,
      STEP_LHS = 7'b0100000,
      STEP_RHS = 7'b1000000
   } step_type;

   logic [otsu_pkg::CNT_W-1:0] mem [otsu_pkg::LEVELS];

   state_type                    state_ff, state_in;
   step_type                     step_ff, step_in;
   logic [otsu_pkg::LVL_W-1:0]   pix_ff, pix_in;
   logic                         last_ff, last_in;
   logic                         cnt_en_ff, cnt_en_in;
   logic [otsu_pkg::CNT_W-1:0]   frame_count_ff, frame_count_in;
   logic [otsu_pkg::SUM_W-1:0]   frame_sum_ff, frame_sum_in;
   logic [otsu_pkg::LEVELS-1:0]  vld_ff, vld_in;
   logic [otsu_pkg::CNT_W-1:0]   rd_data_ff;
   logic                         rd_vld_ff;
   logic [otsu_pkg::LVL_W-1:0]   rd_addr;
   logic [otsu_pkg::LVL_W-1:0]   lv_ff, lv_in;
   logic [otsu_pkg::CNT_W-1:0]   c_ff, c_in;
   logic [otsu_pkg::SUM_W-1:0]   u_ff, u_in;
   logic [otsu_pkg::PROD_W-1:0]  av_ff, av_in;
   logic [otsu_pkg::PROD_W-1:0]  d_ff, d_in;
   logic [otsu_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [otsu_pkg::DSQ_W-1:0]   dsq_ff, dsq_in;
   logic [otsu_pkg::MUL_P_W-1:0] lhs_ff, lhs_in;
   logic [otsu_pkg::DSQ_W-1:0]   best_dsq_ff, best_dsq_in;
   logic [otsu_pkg::DEN_W-1:0]   best_den_ff, best_den_in;
   logic [otsu_pkg::LVL_W-1:0]   thr_ff, thr_in;
   logic                         found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [otsu_pkg::LVL_W-1:0]   rsp_thr_ff, rsp_thr_in;
   logic [otsu_pkg::CNT_W-1:0]   rsp_total_ff, rsp_total_in;

   logic [otsu_pkg::CNT_W-1:0]   bin;
   logic [otsu_pkg::PROD_W-1:0]  prod_lo;
   logic [otsu_pkg::PROD_W-1:0]  d_cand;
   logic                         last_lvl;
   state_type                    lvl_next;

   otsu_pkg::mul_req_type        mul_req;
   otsu_pkg::mul_sts_type        mul_sts;

   otsu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .sts   (mul_sts)
   );

   assign rd_addr  = (state_ff == ST_IDLE) ? req_pixel : lv_ff;
   assign bin      = rd_vld_ff ? rd_data_ff : '0;
   assign prod_lo  = mul_sts.prod[otsu_pkg::PROD_W-1:0];
   assign d_cand   = (av_ff > prod_lo) ? (av_ff - prod_lo) : (prod_lo - av_ff);
   assign last_lvl = (lv_ff == otsu_pkg::LVL_W'(otsu_pkg::LEVELS - 1));
   assign lvl_next = last_lvl ? ST_DONE : ST_RD;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      pix_in         = pix_ff;
      last_in        = last_ff;
      cnt_en_in      = cnt_en_ff;
      frame_count_in = frame_count_ff;
      frame_sum_in   = frame_sum_ff;
      vld_in         = vld_ff;
      lv_in          = lv_ff;
      c_in           = c_ff;
      u_in           = u_ff;
      av_in          = av_ff;
      d_in           = d_ff;
      den_in         = den_ff;
      dsq_in         = dsq_ff;
      lhs_in         = lhs_ff;
      best_dsq_in    = best_dsq_ff;
      best_den_in    = best_den_ff;
      thr_in         = thr_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_thr_in     = rsp_thr_ff;
      rsp_total_in   = rsp_total_ff;
      mul_req        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pix_in    = req_pixel;
               last_in   = req_last_pixel;
               cnt_en_in = (frame_count_ff < otsu_pkg::CNT_W'(otsu_pkg::MAX_PIXELS));
               state_in  = ST_INC;
            end
         end
         ST_INC: begin
            if (cnt_en_ff) begin
               vld_in[pix_ff] = 1'b1;
               frame_count_in = frame_count_ff + 1'b1;
               frame_sum_in   = frame_sum_ff + otsu_pkg::SUM_W'(pix_ff);
            end
            if (last_ff) begin
               lv_in    = '0;
               c_in     = '0;
               u_in     = '0;
               found_in = 1'b0;
               thr_in   = '0;
               state_in = ST_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            state_in = ST_BIN;
         end
         ST_BIN: begin
            c_in          = c_ff + bin;
            mul_req.start = 1'b1;
            mul_req.a     = otsu_pkg::DSQ_W'(bin);
            mul_req.b     = otsu_pkg::MUL_B_W'(lv_ff);
            step_in       = STEP_U;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            if (mul_sts.done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            lv_in = lv_ff + 1'b1;
            case (step_ff)
               STEP_U: begin
                  u_in = u_ff + mul_sts.prod[otsu_pkg::SUM_W-1:0];
                  // skip one-sided levels
                  if ((c_ff == '0) || (c_ff >= frame_count_ff)) begin
                     state_in = lvl_next;
                  end else begin
                     lv_in         = lv_ff;
                     mul_req.start = 1'b1;
                     mul_req.a     = otsu_pkg::DSQ_W'(frame_sum_ff);
                     mul_req.b     = otsu_pkg::MUL_B_W'(c_ff);
                     step_in       = STEP_A;
                     state_in      = ST_MUL;
                  end
               end
               STEP_A: begin
                  lv_in         = lv_ff;
                  av_in         = prod_lo;
                  mul_req.start = 1'b1;
                  mul_req.a     = otsu_pkg::DSQ_W'(u_ff);
                  mul_req.b     = otsu_pkg::MUL_B_W'(frame_count_ff);
                  step_in       = STEP_B;
                  state_in      = ST_MUL;
               end
               STEP_B: begin
                  if (d_cand == '0) begin
                     state_in = lvl_next;
                  end else begin
                     lv_in         = lv_ff;
                     d_in          = d_cand;
                     mul_req.start = 1'b1;
                     mul_req.a     = otsu_pkg::DSQ_W'(c_ff);
                     mul_req.b     = otsu_pkg::MUL_B_W'(frame_count_ff - c_ff);
                     step_in       = STEP_DEN;
                     state_in      = ST_MUL;
                  end
               end
               STEP_DEN: begin
                  lv_in         = lv_ff;
                  den_in        = mul_sts.prod[otsu_pkg::DEN_W-1:0];
                  mul_req.start = 1'b1;
                  mul_req.a     = otsu_pkg::DSQ_W'(d_ff);
                  mul_req.b     = d_ff;
                  step_in       = STEP_SQ;
                  state_in      = ST_MUL;
               end
               STEP_SQ: begin
                  dsq_in = mul_sts.prod[otsu_pkg::DSQ_W-1:0];
                  if (!found_ff) begin
                     found_in    = 1'b1;
                     best_dsq_in = mul_sts.prod[otsu_pkg::DSQ_W-1:0];
                     best_den_in = den_ff;
                     thr_in      = lv_ff;
                     state_in    = lvl_next;
                  end else begin
                     lv_in         = lv_ff;
                     mul_req.start = 1'b1;
                     mul_req.a     = mul_sts.prod[otsu_pkg::DSQ_W-1:0];
                     mul_req.b     = otsu_pkg::MUL_B_W'(best_den_ff);
                     step_in       = STEP_LHS;
                     state_in      = ST_MUL;
                  end
               end
               STEP_LHS: begin
                  lv_in         = lv_ff;
                  lhs_in        = mul_sts.prod;
                  mul_req.start = 1'b1;
                  mul_req.a     = best_dsq_ff;
                  mul_req.b     = otsu_pkg::MUL_B_W'(den_ff);
                  step_in       = STEP_RHS;
                  state_in      = ST_MUL;
               end
               STEP_RHS: begin
                  // strictly larger replaces; ties keep the lower level
                  if (lhs_ff > mul_sts.prod) begin
                     best_dsq_in = dsq_ff;
                     best_den_in = den_ff;
                     thr_in      = lv_ff;
                  end
                  state_in = lvl_next;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DONE: begin
            // hold until the previous result beat leaves
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_thr_in     = thr_ff;
               rsp_total_in   = frame_count_ff;
               frame_count_in = '0;
               frame_sum_in   = '0;
               vld_in         = '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_INC) && cnt_en_ff) begin
         mem[pix_ff] <= (rd_vld_ff ? rd_data_ff : '0) + 1'b1;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= STEP_U;
         frame_count_ff <= '0;
         frame_sum_ff   <= '0;
         vld_ff         <= '0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         frame_count_ff <= frame_count_in;
         frame_sum_ff   <= frame_sum_in;
         vld_ff         <= vld_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_vld_ff      <= vld_ff[rd_addr];
      end
      pix_ff      <= pix_in;
      last_ff     <= last_in;
      cnt_en_ff   <= cnt_en_in;
      lv_ff       <= lv_in;
      c_ff        <= c_in;
      u_ff        <= u_in;
      av_ff       <= av_in;
      d_ff        <= d_in;
      den_ff      <= den_in;
      dsq_ff      <= dsq_in;
      lhs_ff      <= lhs_in;
      best_dsq_ff <= best_dsq_in;
      best_den_ff <= best_den_in;
      thr_ff      <= thr_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_threshold   = rsp_thr_ff;
   assign rsp_pixel_total = rsp_total_ff;

   `OTSU_ASSERT(a_count_cap, clock, reset,
      frame_count_ff <= otsu_pkg::CNT_W'(otsu_pkg::MAX_PIXELS), "frame count above limit")
   `OTSU_ASSERT(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result raised outside sweep end")
   `OTSU_ASSERT(a_eval_mul_idle, clock, reset,
      (state_ff == ST_EVAL) |-> !mul_sts.busy, "product read while multiplier busy")
endmodule

[dv/otsu_threshold_finder_top_tb.sv]
// Testbench for the Otsu threshold finder: directed and random frames checked against a built-in predictor.
`timescale 1ns / 1ps

module otsu_threshold_finder_top_tb;

   localparam int STALL_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLDOFF_LEN  = 150000;

   typedef struct {
      logic [otsu_pkg::LVL_W-1:0] level;
      logic                       last;
      logic                       wait_idle;
   } pixel_beat_type;

   typedef struct {
      logic [otsu_pkg::LVL_W-1:0] threshold;
      logic [otsu_pkg::CNT_W-1:0] total;
   } frame_result_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [otsu_pkg::LVL_W-1:0] req_pixel;
   logic                       req_last_pixel;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [otsu_pkg::LVL_W-1:0] rsp_threshold;
   logic [otsu_pkg::CNT_W-1:0] rsp_pixel_total;

   pixel_beat_type   pixel_q[$];
   frame_result_type frame_result_q[$];

   // histogram state of the predictor
   longint unsigned hist[otsu_pkg::LEVELS];
   longint unsigned frame_pixels;
   longint unsigned frame_sum;

   int  error_count;
   int  results_seen;
   int  idle_cycles;
   int  burst_left;
   int  gap_left;
   bit  holdoff_done;
   int  holdoff_left;
   int  stall_mode;
   int  stall_phase;

   otsu_threshold_finder_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_last_pixel  (req_last_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_threshold   (rsp_threshold),
      .rsp_pixel_total (rsp_pixel_total)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // d^2 * m, wide enough for any frame this block can count
   function automatic logic [191:0] sq_scaled(input longint unsigned d, input longint unsigned m);
      logic [191:0] dd;
      dd = 192'(d);
      return dd * dd * m;
   endfunction

   function automatic logic [otsu_pkg::LVL_W-1:0] best_level();
      longint unsigned c, u, d, den, a, b, best_d, best_den;
      bit found;
      logic [otsu_pkg::LVL_W-1:0] thr;
      c = 0; u = 0; best_d = 0; best_den = 1; found = 0; thr = '0;
      for (int lv = 0; lv < otsu_pkg::LEVELS; lv++) begin
         c += hist[lv];
         u += lv * hist[lv];
         if (c == 0 || c >= frame_pixels) continue;
         den = c * (frame_pixels - c);
         a = frame_sum * c;
         b = u * frame_pixels;
         d = (a > b) ? a - b : b - a;
         if (d == 0) continue;
         // strictly larger only, so the lowest level wins a tie
         if (!found || sq_scaled(d, best_den) > sq_scaled(best_d, den)) begin
            found = 1;
            best_d = d;
            best_den = den;
            thr = lv[otsu_pkg::LVL_W-1:0];
         end
      end
      return thr;
   endfunction

   task automatic count_pixel(input logic [otsu_pkg::LVL_W-1:0] level, input logic last);
      frame_result_type r;
      if (frame_pixels < otsu_pkg::MAX_PIXELS) begin
         hist[level]++;
         frame_pixels++;
         frame_sum += level;
      end
      if (last) begin
         r.threshold = best_level();
         r.total = frame_pixels[otsu_pkg::CNT_W-1:0];
         frame_result_q.push_back(r);
         foreach (hist[i]) hist[i] = 0;
         frame_pixels = 0;
         frame_sum = 0;
      end
   endtask

   task automatic add_frame(input int len, input int shape, input bit wait_idle);
      pixel_beat_type pb;
      int lo, hi;
      lo = $urandom_range(0, 255);
      hi = $urandom_range(0, 255);
      for (int i = 0; i < len; i++) begin
         case (shape)
            0: pb.level = otsu_pkg::LVL_W'($urandom_range(0, 255));
            1: pb.level = otsu_pkg::LVL_W'(($urandom_range(0, 1) ? lo : hi) +
                                           $urandom_range(0, 3));
            2: pb.level = otsu_pkg::LVL_W'($urandom_range(0, 1) ? lo : hi);
            default: pb.level = otsu_pkg::LVL_W'($urandom_range(0, 3) == 0 ?
                                                 $urandom_range(0, 255) : lo);
         endcase
         pb.last = (i == len - 1);
         pb.wait_idle = wait_idle && (i == 0);
         pixel_q.push_back(pb);
      end
   endtask

   task automatic add_levels(input int lv[$]);
      pixel_beat_type pb;
      foreach (lv[i]) begin
         pb.level = otsu_pkg::LVL_W'(lv[i]);
         pb.last = (i == lv.size() - 1);
         pb.wait_idle = 0;
         pixel_q.push_back(pb);
      end
   endtask

   // driver: bursts of beats separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_pixel <= '0;
         req_last_pixel <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) count_pixel(req_pixel, req_last_pixel);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() == 0 ||
                         (pixel_q[0].wait_idle && frame_result_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_pixel <= pixel_q[0].level;
               req_last_pixel <= pixel_q[0].last;
               pixel_q.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(0, 12);
                  gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off after the second frame
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         holdoff_done = 0;
         holdoff_left = 0;
         stall_mode = 0;
         stall_phase = 0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && results_seen == 2) begin
         holdoff_done = 1;
         holdoff_left = HOLDOFF_LEN;
         rsp_stall <= 1'b1;
      end else begin
         stall_phase++;
         if (stall_phase == 97) begin
            stall_phase = 0;
            stall_mode = $urandom_range(0, 2);
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= $urandom_range(0, 7) != 0;
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (frame_result_q.size() == 0) begin
            $display("unexpected result beat, threshold %0d at %0t", rsp_threshold, $realtime);
            error_count++;
         end else begin
            want = frame_result_q.pop_front();
            if (rsp_threshold !== want.threshold)
               report_mismatch("threshold", rsp_threshold, want.threshold);
            if (rsp_pixel_total !== want.total)
               report_mismatch("pixel_total", rsp_pixel_total, want.total);
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int total;
      error_count = 0;
      results_seen = 0;
      frame_pixels = 0;
      frame_sum = 0;
      foreach (hist[i]) hist[i] = 0;
      reset = 1'b1;

      // single pixel, flat frame, extremes, ties and a six-level frame
      add_levels('{255});
      add_levels('{0});
      add_levels('{128, 128, 128, 128, 128});
      add_levels('{0, 255});
      add_levels('{0, 0, 255, 255});
      add_levels('{0, 128, 255, 85, 170, 1});
      total = pixel_q.size();
      while (total < 700) begin
         int len;
         len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 4) : $urandom_range(10, 60);
         add_frame(len, $urandom_range(0, 3), $urandom_range(0, 5) == 0);
         total += len;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pixel_q.size() == 0);
      @(posedge clock);
      while (req_valid || frame_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/otsu_pkg.sv
hw/rtl/otsu_mul.sv
hw/rtl/otsu_threshold_finder_top.sv
dv/otsu_threshold_finder_top_tb.sv
